/* hdl/mscg_pkg.sv */
// Shared constants, stage types and helper functions for the multi-stop colour gradient unit.
// No dependencies; imported by multi_stop_color_gradient_unit.
package mscg_pkg;

    localparam int FRAC_BITS     = 15;
    localparam int MAX_STOPS_DEF = 7;
    localparam int POS_W         = 16;
    localparam int IN_W          = 17;
    localparam int CH_W          = 8;
    localparam int COLOR_W       = 3 * CH_W;
    localparam int STOP_W        = POS_W + COLOR_W;
    localparam int REG_IDX_W     = 3;
    localparam int COUNT_W       = 3;
    localparam int REM_W         = POS_W + 1;
    localparam int PROD_W        = CH_W + POS_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 24;

    localparam logic [POS_W-1:0]   ONE  = POS_W'(1 << FRAC_BITS);
    localparam logic [SUM_W-1:0]   HALF = SUM_W'(1 << (FRAC_BITS - 1));

    localparam logic [REG_IDX_W-1:0] IDX_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] IDX_STOP0 = 3'd1;

    localparam logic [COUNT_W-1:0] RESET_COUNT = 3'd3;
    localparam logic [STOP_W-1:0]  RESET_STOP0 = 40'h00_0000_FF00;
    localparam logic [STOP_W-1:0]  RESET_STOP1 = 40'h40_00FF_FF00;
    localparam logic [STOP_W-1:0]  RESET_STOP2 = 40'h80_00FF_0000;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic               last;
        logic [REM_W-1:0]   rem;
        logic [FRAC_BITS-1:0] quo;
        logic [POS_W-1:0]   den;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
    } div_t;

    function automatic logic [STOP_W-1:0] reset_stop(input int idx);
        logic [STOP_W-1:0] s;
        case (idx)
            0:       s = RESET_STOP0;
            1:       s = RESET_STOP1;
            2:       s = RESET_STOP2;
            default: s = '0;
        endcase
        return s;
    endfunction

    // One restoring division step: shift in a zero, subtract when it fits.
    function automatic div_t div_step(input div_t d);
        div_t             r;
        logic [REM_W-1:0] t;
        r = d;
        t = {d.rem[REM_W-2:0], 1'b0};
        if (t >= {1'b0, d.den})
        begin
            r.rem = t - {1'b0, d.den};
            r.quo = {d.quo[FRAC_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = t;
            r.quo = {d.quo[FRAC_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* hdl/multi_stop_color_gradient_unit.sv */
// Multi-stop colour gradient: position in, interpolated RGB out, pipelined.
// Depends on mscg_pkg.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one signed Q1.15 position per
//   beat; the master stream (m_tvalid/m_tready/m_tdata/m_tuser) returns one colour
//   per beat. Stops and stop count are written through wr_en/wr_index/wr_data; the user
//   must write them only while no beat is in flight, which the block does not enforce.
//   An accepted input beat reaches m_tvalid through twenty register stages (clamp,
//   segment search, operand select, 15 restoring division steps, multiply, round).
//   Throughput: one beat per cycle while the output is not stalled; the fraction divider
//   is one quotient bit per stage, so it never holds back the stream.
//   Reset: stops return to the green-yellow-red heat gradient with three stops;
//   all stage valids clear.
//   Stall: when m_tready is low with a result waiting, every stage holds and one
//   further input beat is taken into a skid register; s_tready then drops until
//   the output moves again. Nothing is lost or repeated.
//   Invalid stops give m_tuser high and black colour.
module multi_stop_color_gradient_unit
    import mscg_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [REG_IDX_W-1:0]   wr_index,
    input  logic [STOP_W-1:0]      wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [16:0] position
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic                   m_tuser    // [0] range_error
);

    localparam int IDX_W = $clog2(MAX_STOPS);

    logic [COUNT_W-1:0] count_reg;
    logic [STOP_W-1:0]  stops_reg [MAX_STOPS];
    logic               cfg_err_reg;
    logic               cfg_err_next;

    logic               en;
    logic               in_take;
    logic               skid_full_reg;
    logic [IN_W-1:0]    skid_pos_reg;
    logic               src_valid;
    logic [IN_W-1:0]    src_pos;
    logic [POS_W-1:0]   clamp_pos;

    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s2_valid_reg;
    logic [POS_W-1:0]   s2_pos_reg;
    logic [IDX_W-1:0]   s2_lo_reg;
    logic [IDX_W-1:0]   s2_lo_next;

    logic               sel_last;
    logic [IDX_W-1:0]   hi_idx;
    logic [STOP_W-1:0]  lo_stop;
    logic [STOP_W-1:0]  hi_stop;
    div_t               s3_reg;
    div_t               s3_next;
    div_t               div_reg  [FRAC_BITS];
    div_t               div_next [FRAC_BITS];

    logic               mul_valid_reg;
    logic               mul_err_reg;
    logic [PROD_W-1:0]  prod_a_reg [3];
    logic [PROD_W-1:0]  prod_b_reg [3];
    logic [PROD_W-1:0]  prod_a_next [3];
    logic [PROD_W-1:0]  prod_b_next [3];
    logic [FRAC_BITS-1:0] frac;
    logic [POS_W-1:0]   wfrac;

    logic [SUM_W-1:0]   sum [3];
    logic [CH_W-1:0]    chan_next [3];
    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_COUNT;
            for (int i = 0; i < MAX_STOPS; i++)
                stops_reg[i] <= reset_stop(i);
        end
        else if (wr_en)
        begin
            if (wr_index == IDX_COUNT)
                count_reg <= wr_data[COUNT_W-1:0];
            for (int i = 0; i < MAX_STOPS; i++)
                if (wr_index == REG_IDX_W'(i + int'(IDX_STOP0)))
                    stops_reg[i] <= wr_data;
        end
    end

    always_comb
    begin
        cfg_err_next = (count_reg < 3'd2) || (count_reg > COUNT_W'(MAX_STOPS));
        if (stops_reg[0][STOP_W-1:COLOR_W] != '0)
            cfg_err_next = 1'b1;
        for (int i = 0; i < MAX_STOPS; i++)
            if (COUNT_W'(i) == count_reg - 3'd1 && stops_reg[i][STOP_W-1:COLOR_W] != ONE)
                cfg_err_next = 1'b1;
        for (int i = 1; i < MAX_STOPS; i++)
            if (COUNT_W'(i) < count_reg &&
                stops_reg[i][STOP_W-1:COLOR_W] <= stops_reg[i-1][STOP_W-1:COLOR_W])
                cfg_err_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_err_reg <= 1'b0;
        else
            cfg_err_reg <= cfg_err_next;
    end

    // input skid and pipeline advance
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = !skid_full_reg;
    assign in_take   = s_tvalid && !skid_full_reg;
    assign src_valid = skid_full_reg || in_take;
    assign src_pos   = skid_full_reg ? skid_pos_reg : s_tdata[IN_W-1:0];

    always_comb
    begin
        if (src_pos[IN_W-1])
            clamp_pos = '0;
        else if (src_pos[POS_W-1:0] > ONE)
            clamp_pos = ONE;
        else
            clamp_pos = src_pos[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            skid_pos_reg  <= '0;
        end
        else if (en)
            skid_full_reg <= 1'b0;
        else if (in_take)
        begin
            skid_full_reg <= 1'b1;
            skid_pos_reg  <= s_tdata[IN_W-1:0];
        end
    end

    // segment search: last used stop at or below the position
    always_comb
    begin
        s2_lo_next = '0;
        for (int i = 1; i < MAX_STOPS; i++)
            if (COUNT_W'(i) < count_reg && stops_reg[i][STOP_W-1:COLOR_W] <= s1_pos_reg)
                s2_lo_next = IDX_W'(i);
    end

    // operand select for the fraction divide
    always_comb
    begin
        sel_last = (COUNT_W'(s2_lo_reg) == count_reg - 3'd1);
        if (sel_last || s2_lo_reg == IDX_W'(MAX_STOPS - 1))
            hi_idx = s2_lo_reg;
        else
            hi_idx = s2_lo_reg + IDX_W'(1);
        lo_stop       = stops_reg[s2_lo_reg];
        hi_stop       = stops_reg[hi_idx];
        s3_next.valid = s2_valid_reg;
        s3_next.err   = cfg_err_reg;
        s3_next.last  = sel_last;
        s3_next.rem   = {1'b0, s2_pos_reg - lo_stop[STOP_W-1:COLOR_W]};
        s3_next.quo   = '0;
        s3_next.den   = hi_stop[STOP_W-1:COLOR_W] - lo_stop[STOP_W-1:COLOR_W];
        s3_next.c1    = lo_stop[COLOR_W-1:0];
        s3_next.c2    = hi_stop[COLOR_W-1:0];
    end

    always_comb
    begin
        div_next[0] = div_step(s3_reg);
        for (int k = 1; k < FRAC_BITS; k++)
            div_next[k] = div_step(div_reg[k-1]);
    end

    // weights and products
    always_comb
    begin
        frac  = div_reg[FRAC_BITS-1].last ? '0 : div_reg[FRAC_BITS-1].quo;
        wfrac = ONE - {{(POS_W-FRAC_BITS){1'b0}}, frac};
        for (int k = 0; k < 3; k++)
        begin
            prod_a_next[k] = {{POS_W{1'b0}}, div_reg[FRAC_BITS-1].c1[COLOR_W-1-CH_W*k -: CH_W]}
                             * {{CH_W{1'b0}}, wfrac};
            prod_b_next[k] = {{POS_W{1'b0}}, div_reg[FRAC_BITS-1].c2[COLOR_W-1-CH_W*k -: CH_W]}
                             * {{(PROD_W-FRAC_BITS){1'b0}}, frac};
        end
    end

    // round and drop the fraction bits; index 0 is red
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k]       = {1'b0, prod_a_reg[k]} + {1'b0, prod_b_reg[k]} + HALF;
            chan_next[k] = mul_err_reg ? '0 : sum[k][FRAC_BITS+CH_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_pos_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            s2_pos_reg    <= '0;
            s2_lo_reg     <= '0;
            s3_reg        <= '0;
            for (int k = 0; k < FRAC_BITS; k++)
                div_reg[k] <= '0;
            mul_valid_reg <= 1'b0;
            mul_err_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                prod_a_reg[k] <= '0;
                prod_b_reg[k] <= '0;
            end
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= src_valid;
            s1_pos_reg    <= clamp_pos;
            s2_valid_reg  <= s1_valid_reg;
            s2_pos_reg    <= s1_pos_reg;
            s2_lo_reg     <= s2_lo_next;
            s3_reg        <= s3_next;
            for (int k = 0; k < FRAC_BITS; k++)
                div_reg[k] <= div_next[k];
            mul_valid_reg <= div_reg[FRAC_BITS-1].valid;
            mul_err_reg   <= div_reg[FRAC_BITS-1].err;
            for (int k = 0; k < 3; k++)
            begin
                prod_a_reg[k] <= prod_a_next[k];
                prod_b_reg[k] <= prod_b_next[k];
            end
            m_tvalid_reg  <= mul_valid_reg;
            m_tdata_reg   <= {chan_next[2], chan_next[1], chan_next[0]};
            m_tuser_reg   <= mul_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error beat carries a colour");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && en |=> !skid_full_reg)
        else $error("skid register not drained on advance");

    a_ready_low_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(!en))
        else $error("input refused without an output stall");

endmodule
